// ===== rtl/adc_sr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC serial readout package
// Types, register indexes, phase codes and sample extension shared by the
// readout controller modules.
// ----------------------------------------------------------------------------
package adc_sr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PC_W        = $clog2(SAMPLE_BITS + 3);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [23:0] WAIT_MAX = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CHANNEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_DOWN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 3'd6;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_READ     = 2'd1;
    localparam logic [1:0] ACT_READ_CAL = 2'd2;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WAIT     = 3'd1;
    localparam logic [2:0] PH_HIGH     = 3'd2;
    localparam logic [2:0] PH_LOW      = 3'd3;
    localparam logic [2:0] PH_WAIT_CAL = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic       dout_level;
    } t_in_item;

    typedef struct packed {
        logic              sclk;
        logic              pdwn_n;
        logic              speed_pin;
        logic              chan_pin;
        logic              gain0_pin;
        logic              gain1_pin;
        logic              temp_pin;
        logic signed [23:0] sample;
        logic              sample_valid;
        logic              calib_done;
        logic              timed_out;
        logic              busy_res;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  gain_code;
        logic        fast_rate;
        logic        second_channel;
        logic        temp_mode;
        logic        power_down;
        logic [23:0] timeout_ticks;
        logic [7:0]  half_period_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]             phase;
        logic [PC_W-1:0]        pulse_count;
        logic [SAMPLE_BITS-1:0] shift_bits;
        logic [23:0]            wait_count;
        logic [7:0]             half_count;
        logic                   calib_pending;
        logic [23:0]            last_sample;
    } t_state;

    function automatic logic [23:0] extend_sample(input logic [SAMPLE_BITS-1:0] bits);
        logic [23:0] v;
        for (int i = 0; i < 24; i++) begin
            if (i < SAMPLE_BITS) begin
                v[i] = bits[i];
            end else begin
                v[i] = bits[SAMPLE_BITS-1];
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/adc_sr_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC serial readout configuration registers
// Write-only register file holding pin levels and timing settings.
// ----------------------------------------------------------------------------
module adc_sr_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [adc_sr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [adc_sr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output adc_sr_pkg::t_cfg                         o_cfg
);
    import adc_sr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_code         <= 2'd3;
            r_cfg.fast_rate         <= 1'b0;
            r_cfg.second_channel    <= 1'b0;
            r_cfg.temp_mode         <= 1'b0;
            r_cfg.power_down        <= 1'b0;
            r_cfg.timeout_ticks     <= 24'd500000;
            r_cfg.half_period_ticks <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_CODE:      r_cfg.gain_code         <= i_cfg_data[1:0];
                REG_FAST_RATE:      r_cfg.fast_rate         <= i_cfg_data[0];
                REG_SECOND_CHANNEL: r_cfg.second_channel    <= i_cfg_data[0];
                REG_TEMP_MODE:      r_cfg.temp_mode         <= i_cfg_data[0];
                REG_POWER_DOWN:     r_cfg.power_down        <= i_cfg_data[0];
                REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks     <= i_cfg_data[23:0];
                REG_HALF_PERIOD:    r_cfg.half_period_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/adc_sr_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC serial readout tick logic
// Next-state and result logic for one tick of the readout sequencer.
// ----------------------------------------------------------------------------
module adc_sr_core (
    input  wire adc_sr_pkg::t_cfg     i_cfg,
    input  wire adc_sr_pkg::t_state   i_state,
    input  wire adc_sr_pkg::t_in_item i_item,
    output adc_sr_pkg::t_state        o_state,
    output adc_sr_pkg::t_out_item     o_result
);
    import adc_sr_pkg::*;

    t_state      n;
    logic [23:0] limit;
    logic [7:0]  hp;
    logic [23:0] wc_inc;
    logic [8:0]  hc_inc;
    logic [PC_W-1:0] pc_inc;
    logic        half_done;
    logic        wait_ready;
    logic        wait_tout;
    logic        sclk;
    logic        valid;
    logic        cdone;
    logic        tout;

    assign limit = (i_cfg.timeout_ticks != 24'd0) ? i_cfg.timeout_ticks : 24'd1;
    assign hp    = (i_cfg.half_period_ticks != 8'd0) ? i_cfg.half_period_ticks : 8'd1;

    always_comb begin
        n     = i_state;
        sclk  = 1'b0;
        valid = 1'b0;
        cdone = 1'b0;
        tout  = 1'b0;

        if (n.phase == PH_IDLE &&
            (i_item.action == ACT_READ || i_item.action == ACT_READ_CAL)) begin
            n.calib_pending = (i_item.action == ACT_READ_CAL);
            n.wait_count    = 24'd0;
            n.pulse_count   = '0;
            n.shift_bits    = '0;
            n.phase         = PH_WAIT;
        end

        wc_inc     = (n.wait_count != WAIT_MAX) ? n.wait_count + 24'd1 : n.wait_count;
        wait_ready = !i_item.dout_level;
        wait_tout  = i_item.dout_level && (wc_inc >= limit);
        hc_inc     = {1'b0, n.half_count} + 9'd1;
        half_done  = (hc_inc >= {1'b0, hp});
        pc_inc     = n.pulse_count + PC_W'(1);

        unique case (n.phase)
            PH_IDLE: ;
            PH_WAIT: begin
                if (wait_ready) begin
                    n.phase       = PH_HIGH;
                    n.half_count  = 8'd0;
                    n.pulse_count = '0;
                end else begin
                    n.wait_count = wc_inc;
                    if (wait_tout) begin
                        tout    = 1'b1;
                        n.phase = PH_IDLE;
                    end
                end
            end
            PH_HIGH: begin
                sclk = 1'b1;
                if (half_done) begin
                    if (n.pulse_count < PC_W'(SAMPLE_BITS)) begin
                        n.shift_bits = {n.shift_bits[SAMPLE_BITS-2:0], i_item.dout_level};
                    end
                    n.half_count = 8'd0;
                    n.phase      = PH_LOW;
                end else begin
                    n.half_count = hc_inc[7:0];
                end
            end
            PH_LOW: begin
                if (half_done) begin
                    n.half_count  = 8'd0;
                    n.pulse_count = pc_inc;
                    if (pc_inc < PC_W'(SAMPLE_BITS + 1)) begin
                        n.phase = PH_HIGH;
                    end else if (pc_inc == PC_W'(SAMPLE_BITS + 1)) begin
                        n.last_sample = extend_sample(n.shift_bits);
                        valid         = 1'b1;
                        n.phase       = n.calib_pending ? PH_HIGH : PH_IDLE;
                    end else begin
                        n.wait_count = 24'd0;
                        n.phase      = PH_WAIT_CAL;
                    end
                end else begin
                    n.half_count = hc_inc[7:0];
                end
            end
            PH_WAIT_CAL: begin
                if (wait_ready) begin
                    cdone           = 1'b1;
                    n.calib_pending = 1'b0;
                    n.phase         = PH_IDLE;
                end else begin
                    n.wait_count = wc_inc;
                    if (wait_tout) begin
                        tout            = 1'b1;
                        n.calib_pending = 1'b0;
                        n.phase         = PH_IDLE;
                    end
                end
            end
            default: n.phase = PH_IDLE;
        endcase
    end

    assign o_state = n;

    always_comb begin
        o_result.sclk         = sclk;
        o_result.pdwn_n       = !i_cfg.power_down;
        o_result.speed_pin    = i_cfg.fast_rate;
        o_result.chan_pin     = i_cfg.second_channel;
        o_result.gain0_pin    = i_cfg.gain_code[0];
        o_result.gain1_pin    = i_cfg.gain_code[1];
        o_result.temp_pin     = i_cfg.temp_mode;
        o_result.sample       = n.last_sample;
        o_result.sample_valid = valid;
        o_result.calib_done   = cdone;
        o_result.timed_out    = tout;
        o_result.busy_res     = (n.phase != PH_IDLE);
    end

endmodule
`default_nettype wire

// ===== rtl/adc_serial_readout_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC serial readout controller
// Host-side sequencer for a 24-bit delta-sigma converter: ready wait with
// timeout, serial clocking of the sample, acknowledge and calibrate pulses.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// in       | input     | i_in_valid/o_in_stall | i_in_item  (one tick)
// out      | output    | o_out_valid/i_out_stall | o_out_item (one per tick)
// cfg      | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One request per cycle unless stalled; each passes input then result register.
// The sequencer state advances as a request moves from input to result register.
// Reset is synchronous and clears handshake, sequencer and configuration state.
// An output stall holds the result and a full input register; o_in_stall rises.
// ----------------------------------------------------------------------------
module adc_serial_readout_controller (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire adc_sr_pkg::t_in_item              i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output adc_sr_pkg::t_out_item                  o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [adc_sr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [adc_sr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import adc_sr_pkg::*;

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      out_ready;
    logic      advance;
    logic      in_take;

    adc_sr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    adc_sr_core u_core (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== sim/adc_sr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADC serial readout checker
// Watches the tick, result and register ports of the readout controller,
// keeps its own copy of the sequencer and registers, works out the result of
// every accepted tick and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module adc_sr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  adc_sr_pkg::t_in_item              i_in_item,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  adc_sr_pkg::t_out_item             i_out_item,
    input  logic                              i_cfg_we,
    input  logic [adc_sr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [adc_sr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output logic                              o_seq_busy
);
    import adc_sr_pkg::*;

    t_cfg                   shadow_cfg;
    logic [2:0]             seq_phase;
    int                     pulses;
    logic [SAMPLE_BITS-1:0] shift_reg;
    logic [23:0]            wait_ticks;
    logic [7:0]             half_ticks;
    logic                   cal_pending;
    logic [23:0]            held_sample;
    t_out_item              expected_ticks[$];
    t_out_item              predicted;
    t_out_item              oldest;
    int                     fails = 0;

    assign o_fail_count = fails;

    task automatic step_readout(input t_in_item req, output t_out_item res);
        logic [7:0]  hp;
        logic [23:0] limit;
        logic        level;
        logic        expired;
        hp      = (shadow_cfg.half_period_ticks == 8'd0) ? 8'd1 : shadow_cfg.half_period_ticks;
        limit   = (shadow_cfg.timeout_ticks == 24'd0) ? 24'd1 : shadow_cfg.timeout_ticks;
        level   = req.dout_level;
        expired = 1'b0;
        res     = '0;
        if (seq_phase == PH_IDLE && (req.action == ACT_READ || req.action == ACT_READ_CAL)) begin
            cal_pending = (req.action == ACT_READ_CAL);
            wait_ticks  = '0;
            pulses      = 0;
            shift_reg   = '0;
            seq_phase   = PH_WAIT;
        end
        case (seq_phase)
            PH_WAIT, PH_WAIT_CAL: begin
                if (level) begin
                    if (wait_ticks != WAIT_MAX) begin
                        wait_ticks = wait_ticks + 24'd1;
                    end
                    expired = (wait_ticks >= limit);
                end
                if (!level && seq_phase == PH_WAIT) begin
                    seq_phase  = PH_HIGH;
                    half_ticks = '0;
                    pulses     = 0;
                end else if (!level) begin
                    res.calib_done = 1'b1;
                    cal_pending    = 1'b0;
                    seq_phase      = PH_IDLE;
                end else if (expired) begin
                    res.timed_out = 1'b1;
                    cal_pending   = 1'b0;
                    seq_phase     = PH_IDLE;
                end
            end
            PH_HIGH: begin
                res.sclk   = 1'b1;
                half_ticks = half_ticks + 8'd1;
                if (half_ticks >= hp) begin
                    if (pulses < SAMPLE_BITS) begin
                        shift_reg = {shift_reg[SAMPLE_BITS-2:0], level};
                    end
                    half_ticks = '0;
                    seq_phase  = PH_LOW;
                end
            end
            PH_LOW: begin
                half_ticks = half_ticks + 8'd1;
                if (half_ticks >= hp) begin
                    half_ticks = '0;
                    pulses++;
                    if (pulses < SAMPLE_BITS + 1) begin
                        seq_phase = PH_HIGH;
                    end else if (pulses == SAMPLE_BITS + 1) begin
                        held_sample      = 24'($signed(shift_reg));
                        res.sample_valid = 1'b1;
                        seq_phase        = cal_pending ? PH_HIGH : PH_IDLE;
                    end else begin
                        wait_ticks = '0;
                        seq_phase  = PH_WAIT_CAL;
                    end
                end
            end
            default: begin
                seq_phase = PH_IDLE;
            end
        endcase
        res.pdwn_n    = !shadow_cfg.power_down;
        res.speed_pin = shadow_cfg.fast_rate;
        res.chan_pin  = shadow_cfg.second_channel;
        res.gain0_pin = shadow_cfg.gain_code[0];
        res.gain1_pin = shadow_cfg.gain_code[1];
        res.temp_pin  = shadow_cfg.temp_mode;
        res.sample    = held_sample;
        res.busy_res  = (seq_phase != PH_IDLE);
    endtask

    task automatic compare_field(input string name, input logic [23:0] want,
                                 input logic [23:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_cfg = '{gain_code: 2'd3, fast_rate: 1'b0, second_channel: 1'b0,
                           temp_mode: 1'b0, power_down: 1'b0, timeout_ticks: 24'd500000,
                           half_period_ticks: 8'd1};
            seq_phase   = PH_IDLE;
            pulses      = 0;
            shift_reg   = '0;
            wait_ticks  = '0;
            half_ticks  = '0;
            cal_pending = 1'b0;
            held_sample = '0;
            expected_ticks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    $error("result delivered with no request outstanding");
                    fails++;
                end else begin
                    oldest = expected_ticks.pop_front();
                    compare_field("sclk", oldest.sclk, i_out_item.sclk);
                    compare_field("pdwn_n", oldest.pdwn_n, i_out_item.pdwn_n);
                    compare_field("speed_pin", oldest.speed_pin, i_out_item.speed_pin);
                    compare_field("chan_pin", oldest.chan_pin, i_out_item.chan_pin);
                    compare_field("gain0_pin", oldest.gain0_pin, i_out_item.gain0_pin);
                    compare_field("gain1_pin", oldest.gain1_pin, i_out_item.gain1_pin);
                    compare_field("temp_pin", oldest.temp_pin, i_out_item.temp_pin);
                    compare_field("sample", oldest.sample, i_out_item.sample);
                    compare_field("sample_valid", oldest.sample_valid,
                                  i_out_item.sample_valid);
                    compare_field("calib_done", oldest.calib_done, i_out_item.calib_done);
                    compare_field("timed_out", oldest.timed_out, i_out_item.timed_out);
                    compare_field("busy_res", oldest.busy_res, i_out_item.busy_res);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_CODE:      shadow_cfg.gain_code         = i_cfg_data[1:0];
                    REG_FAST_RATE:      shadow_cfg.fast_rate         = i_cfg_data[0];
                    REG_SECOND_CHANNEL: shadow_cfg.second_channel    = i_cfg_data[0];
                    REG_TEMP_MODE:      shadow_cfg.temp_mode         = i_cfg_data[0];
                    REG_POWER_DOWN:     shadow_cfg.power_down        = i_cfg_data[0];
                    REG_TIMEOUT_TICKS:  shadow_cfg.timeout_ticks     = i_cfg_data[23:0];
                    REG_HALF_PERIOD:    shadow_cfg.half_period_ticks = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                step_readout(i_in_item, predicted);
                expected_ticks.push_back(predicted);
            end
        end
        o_pending  <= expected_ticks.size();
        o_seq_busy <= (seq_phase != PH_IDLE);
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADC serial readout controller testbench
// Drives tick requests shaped as ready waits, serial sample clocking and
// calibration sequences with random data, timeouts and stray requests, under
// several register settings and sender/receiver idling mixes. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import adc_sr_pkg::*;

    localparam logic [1:0]           ACT_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 3'd7;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   PHASE_REQUESTS = 400;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   fail_count;
    int   pending;
    logic seq_busy;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   sent        = 0;
    int   quiet_cycles = 0;
    int   hp_eff      = 1;
    int   timeout_eff = 500000;
    int   gap_plan[4]   = '{0, 63, 0, 15};
    int   stall_plan[4] = '{0, 0, 63, 15};

    adc_serial_readout_controller i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    adc_sr_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seq_busy   (seq_busy)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("adc_serial_readout_controller test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [1:0] stray_action(input int pct);
        if ($urandom_range(99) < pct) begin
            return 2'($urandom_range(1, 3));
        end
        return ACT_TICK;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pad_upper(input logic [CFG_DATA_W-1:0] v,
                                                         input int w);
        return (CFG_DATA_W'($urandom) << w) | v;
    endfunction

    task automatic send_tick(input logic [1:0] act, input logic lvl);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{action: act, dout_level: lvl};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain_sequencer();
        send_tick(ACT_TICK, 1'b0);
        while (seq_busy) send_tick(ACT_TICK, 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] gain, input logic fast, input logic chan,
                             input logic temp, input logic pdown,
                             input logic [23:0] timeout, input logic [7:0] half);
        drain_sequencer();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_GAIN_CODE, pad_upper(gain, 2));
        write_reg(REG_FAST_RATE, pad_upper(fast, 1));
        write_reg(REG_SECOND_CHANNEL, pad_upper(chan, 1));
        write_reg(REG_TEMP_MODE, pad_upper(temp, 1));
        write_reg(REG_POWER_DOWN, pad_upper(pdown, 1));
        write_reg(REG_TIMEOUT_TICKS, timeout);
        write_reg(REG_HALF_PERIOD, pad_upper(half, 8));
        cfg_we      <= 1'b0;
        hp_eff      = (half == 8'd0) ? 1 : half;
        timeout_eff = (timeout == 24'd0) ? 1 : timeout;
    endtask

    task automatic read_sequence(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] data,
                                 input int pre_wait, input int cal_wait, input int noise);
        int last_pulse;
        last_pulse = (act == ACT_READ_CAL) ? SAMPLE_BITS + 1 : SAMPLE_BITS;
        send_tick(act, pre_wait != 0);
        for (int k = 1; k < pre_wait; k++) send_tick(stray_action(noise), 1'b1);
        if (pre_wait != 0) send_tick(stray_action(noise), 1'b0);
        for (int p = 0; p <= last_pulse; p++) begin
            for (int k = 0; k < hp_eff; k++) begin
                if (k == hp_eff - 1 && p < SAMPLE_BITS) begin
                    send_tick(stray_action(noise), data[SAMPLE_BITS-1-p]);
                end else begin
                    send_tick(stray_action(noise), 1'($urandom_range(1)));
                end
            end
            for (int k = 0; k < hp_eff; k++) send_tick(stray_action(noise), 1'($urandom_range(1)));
        end
        if (act == ACT_READ_CAL) begin
            for (int k = 0; k < cal_wait; k++) send_tick(stray_action(noise), 1'b1);
            send_tick(stray_action(noise), 1'b0);
        end
    endtask

    task automatic random_traffic(input int quota);
        int                     start;
        int                     wait_cap;
        logic [1:0]             act;
        logic [SAMPLE_BITS-1:0] data;
        start    = sent;
        wait_cap = (timeout_eff < 28) ? timeout_eff + 2 : 30;
        while (sent - start < quota) begin
            if ($urandom_range(9) < 8) begin
                act = $urandom_range(1) ? ACT_READ_CAL : ACT_READ;
                case ($urandom_range(7))
                    0:       data = '1;
                    1:       data = '0;
                    2:       data = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    3:       data = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    default: data = SAMPLE_BITS'($urandom);
                endcase
                read_sequence(act, data, $urandom_range(wait_cap), $urandom_range(wait_cap), 4);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_tick(2'($urandom_range(3)), 1'($urandom_range(1)));
                end
                drain_sequencer();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_tick(ACT_TICK, 1'b1);
        send_tick(ACT_TICK, 1'b0);
        send_tick(ACT_SPARE, 1'b0);
        send_tick(ACT_SPARE, 1'b1);
        read_sequence(ACT_READ, '1, 0, 0, 0);
        read_sequence(ACT_READ_CAL, {1'b1, {(SAMPLE_BITS-1){1'b0}}}, 3, 2, 0);
        read_sequence(ACT_READ, {1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1, 0, 100);

        configure(2'd0, 1'b1, 1'b1, 1'b1, 1'b1, 24'd0, 8'd0);
        read_sequence(ACT_READ, SAMPLE_BITS'($urandom), 4, 0, 0);
        read_sequence(ACT_READ_CAL, '0, 0, 3, 0);
        read_sequence(ACT_READ_CAL, SAMPLE_BITS'($urandom), 0, 0, 0);

        configure(2'd2, 1'b0, 1'b1, 1'b0, 1'b1, 24'hFFFFFF, 8'd4);
        read_sequence(ACT_READ_CAL, SAMPLE_BITS'($urandom), 2, 1, 5);

        for (int ph = 0; ph < 4; ph++) begin
            logic [23:0] timeout;
            logic [7:0]  half;
            case ($urandom_range(3))
                0:       timeout = 24'd1;
                1:       timeout = 24'd2;
                2:       timeout = 24'($urandom_range(3, 40));
                default: timeout = 24'd500000;
            endcase
            case ($urandom_range(5))
                0:       half = 8'd0;
                1:       half = 8'd2;
                2:       half = 8'd3;
                default: half = 8'd1;
            endcase
            configure(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)), timeout, half);
            gap_pct   = gap_plan[ph];
            stall_pct = stall_plan[ph];
            random_traffic(PHASE_REQUESTS);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("adc_serial_readout_controller test passed");
        end else begin
            $display("adc_serial_readout_controller test failed");
        end
        $finish;
    end

endmodule

// ===== adc_serial_readout_controller.f =====
rtl/adc_sr_pkg.sv
rtl/adc_sr_cfg.sv
rtl/adc_sr_core.sv
rtl/adc_serial_readout_controller.sv
sim/adc_sr_checker.sv
sim/tb.sv
